// ----- rtl/gvg_pkg.sv -----
// Shared types, constants and helpers of the grid vertex generator.
// Used by the top level, the pipelined divider, the hash pipeline and the checker.
package gvg_pkg;

   // Quotient bits that the restoring divider produces, one per pipeline stage.
   localparam int QUO_W = 31;

   // Stages of the hash pipeline from its input to its registered output.
   localparam int HASH_LAT = 6;

   // Rising edges from the accepting edge to the edge that takes the result.
   localparam int LATENCY = QUO_W + 6;

   // Mesh modes.
   localparam logic [1:0] MODE_UNIFORM   = 2'd0;
   localparam logic [1:0] MODE_PERTURBED = 2'd1;
   localparam logic [1:0] MODE_SINE      = 2'd2;

   // Register indexes on the configuration port (byte address 8 * index).
   localparam logic [2:0] REG_MESH_MODE    = 3'd0;
   localparam logic [2:0] REG_GRID_LAST    = 3'd1;
   localparam logic [2:0] REG_ORIGIN_X     = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd3;
   localparam logic [2:0] REG_EXTENT_X     = 3'd4;
   localparam logic [2:0] REG_EXTENT_Y     = 3'd5;
   localparam logic [2:0] REG_JITTER       = 3'd6;
   localparam logic [2:0] REG_NOISE_SEED   = 3'd7;

   // Register reset values.
   localparam logic [31:0] GRID_LAST_RESET = 32'h0001_0001;
   localparam logic [30:0] EXTENT_RESET    = 31'd65536;

   // Hash constants.
   localparam logic [63:0] HASH_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] HASH_MIX1   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] HASH_MIX2   = 64'h94d0_49bb_1331_11eb;

   // Half pi in Q2.30, the argument scale of the sine table.
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   // Flags that travel with a transaction through the pipeline.
   typedef struct packed {
      logic       valid;
      logic [1:0] zero;      // Index is 0, per axis (x is bit 0).
      logic [1:0] last;      // Index is the last index, per axis.
      logic       interior;  // Both indices strictly inside the grid.
   } side_type;

   // Signed noise of one axis as sign and magnitude, magnitude up to 65536.
   typedef struct packed {
      logic        neg;
      logic [16:0] mag;
   } noise_type;

   // Saturate a signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/gvg_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gvg_pkg for the quotient width; the remainder must start below the divisor.
module gvg_div #(
   parameter int DEN_W = 16
) (
   input  logic                             clock,
   input  logic [DEN_W+gvg_pkg::QUO_W-1:0]  num_in,
   input  logic [DEN_W-1:0]                 den_in,
   output logic [gvg_pkg::QUO_W-1:0]        quo_out
);

   localparam int QW = gvg_pkg::QUO_W;

   logic [DEN_W-1:0] rem_ff  [QW];
   logic [QW-1:0]    word_ff [QW];

   // One step: bring down the next dividend bit and subtract where it fits.
   function automatic logic [DEN_W+QW-1:0] div_step(logic [DEN_W-1:0] rem,
                                                    logic [QW-1:0]    word,
                                                    logic [DEN_W-1:0] den);
      logic [DEN_W:0]   part;
      logic [DEN_W+1:0] diff;
      logic [DEN_W-1:0] rem_next;
      logic             qbit;
      part = {rem, word[QW-1]};
      diff = {1'b0, part} - {2'b00, den};
      if (diff[DEN_W+1]) begin
         rem_next = part[DEN_W-1:0];
         qbit     = 1'b0;
      end else begin
         rem_next = diff[DEN_W-1:0];
         qbit     = 1'b1;
      end
      return {rem_next, word[QW-2:0], qbit};
   endfunction

   // The dividend word shifts out its bits while quotient bits shift in.
   always_ff @(posedge clock) begin
      {rem_ff[0], word_ff[0]} <= div_step(num_in[DEN_W+QW-1:QW], num_in[QW-1:0], den_in);
      for (int i = 1; i < QW; i++) begin
         {rem_ff[i], word_ff[i]} <= div_step(rem_ff[i-1], word_ff[i-1], den_in);
      end
   end

   assign quo_out = word_ff[QW-1];

endmodule

// ----- rtl/gvg_hash.sv -----
// Splitmix64 finalizer pipeline that turns a vertex key into signed Q1.16 noise.
// Depends on gvg_pkg for the hash constants and the noise type.
module gvg_hash (
   input  logic                clock,
   input  logic [63:0]         key_in,
   output gvg_pkg::noise_type  noise_out
);

   logic [63:0] v_ff;
   logic [63:0] ll1_ff;
   logic [31:0] m1a_ff, m1b_ff;
   logic [63:0] p1_ff;
   logic [63:0] ll2_ff;
   logic [31:0] m2a_ff, m2b_ff;
   logic [63:0] p2_ff;
   gvg_pkg::noise_type noise_ff;

   logic [63:0] mix_a;
   logic [63:0] mix_b;
   logic [63:0] hash_w;

   always_comb begin
      mix_a  = v_ff ^ (v_ff >> 30);
      mix_b  = p1_ff ^ (p1_ff >> 27);
      hash_w = p2_ff ^ (p2_ff >> 31);
   end

   // Each 64-bit product is cut into three 32-bit partial products, then summed.
   always_ff @(posedge clock) begin
      v_ff   <= key_in + gvg_pkg::HASH_GOLDEN;
      ll1_ff <= 64'(mix_a[31:0]) * 64'(gvg_pkg::HASH_MIX1[31:0]);
      m1a_ff <= 32'(mix_a[31:0] * gvg_pkg::HASH_MIX1[63:32]);
      m1b_ff <= 32'(mix_a[63:32] * gvg_pkg::HASH_MIX1[31:0]);
      p1_ff  <= ll1_ff + {m1a_ff + m1b_ff, 32'd0};
      ll2_ff <= 64'(mix_b[31:0]) * 64'(gvg_pkg::HASH_MIX2[31:0]);
      m2a_ff <= 32'(mix_b[31:0] * gvg_pkg::HASH_MIX2[63:32]);
      m2b_ff <= 32'(mix_b[63:32] * gvg_pkg::HASH_MIX2[31:0]);
      p2_ff  <= ll2_ff + {m2a_ff + m2b_ff, 32'd0};
      // Noise is the top 17 bits minus 65536; a clear top bit means negative.
      noise_ff.neg <= ~hash_w[63];
      if (hash_w[63]) begin
         noise_ff.mag <= {1'b0, hash_w[62:47]};
      end else begin
         noise_ff.mag <= 17'd65536 - {1'b0, hash_w[62:47]};
      end
   end

   assign noise_out = noise_ff;

endmodule

// ----- rtl/grid_vertex_generator.sv -----
// Top level of the grid vertex generator: configuration registers and the vertex pipeline.
// Depends on gvg_pkg, gvg_div and gvg_hash.
//
// Throughput: one vertex per cycle; busy stays low and start is taken in every cycle.
// Each result passes the input stage, the 31-stage pipelined divider, and the table,
// multiply and saturation stages before it appears at the outputs.
// The receiver cannot stall, so rsp_valid is a one-cycle strobe per transaction.
// Synchronous reset empties the pipeline and loads the register defaults.
module grid_vertex_generator #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int INDEX_BITS       = 16
) (
   input  logic               clock,
   input  logic               reset,
   // Input channel.
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_col_index,
   input  logic [15:0]        req_row_index,
   // Result channel.
   output logic               rsp_valid,
   output logic signed [31:0] rsp_coord_x,
   output logic signed [31:0] rsp_coord_y,
   // Configuration port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   localparam int IB        = INDEX_BITS;
   localparam int QW        = gvg_pkg::QUO_W;
   localparam int NUM_W     = IB + QW;
   localparam int KEY_W     = 2 * IB + 1;
   localparam int KW        = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int NOISE_DLY = QW - 1 - gvg_pkg::HASH_LAT;
   localparam int unsigned TERM_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

   typedef logic [16:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave table: a Q30 Taylor series rounded to Q16, capped at one.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type       rom;
      logic [63:0]        x;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (64'(gvg_pkg::HALF_PI_Q30) * 64'(k)) / SINE_TABLE_DEPTH;
         term = x;
         sum  = signed'(x);
         for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TERM_DIV[n];
            if ((n & 1) != 0) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         r = (unsigned'(sum) + 64'd8192) >> 14;
         if (r > 64'd65536) begin
            r = 64'd65536;
         end
         rom[k] = r[16:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Configuration registers.
   logic [1:0]  mesh_mode_ff;
   logic [31:0] grid_last_ff;
   logic [31:0] origin_x_ff;
   logic [31:0] origin_y_ff;
   logic [30:0] extent_x_ff;
   logic [30:0] extent_y_ff;
   logic [13:0] jitter_ff;
   logic [63:0] noise_seed_ff;

   logic        cfg_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mesh_mode_ff  <= gvg_pkg::MODE_UNIFORM;
         grid_last_ff  <= gvg_pkg::GRID_LAST_RESET;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         extent_x_ff   <= gvg_pkg::EXTENT_RESET;
         extent_y_ff   <= gvg_pkg::EXTENT_RESET;
         jitter_ff     <= '0;
         noise_seed_ff <= '0;
      end else if (cfg_write) begin
         unique case (paddr[5:3])
            gvg_pkg::REG_MESH_MODE:  mesh_mode_ff  <= pwdata[1:0];
            gvg_pkg::REG_GRID_LAST:  grid_last_ff  <= pwdata[31:0];
            gvg_pkg::REG_ORIGIN_X:   origin_x_ff   <= pwdata[31:0];
            gvg_pkg::REG_ORIGIN_Y:   origin_y_ff   <= pwdata[31:0];
            gvg_pkg::REG_EXTENT_X:   extent_x_ff   <= pwdata[30:0];
            gvg_pkg::REG_EXTENT_Y:   extent_y_ff   <= pwdata[30:0];
            gvg_pkg::REG_JITTER:     jitter_ff     <= pwdata[13:0];
            gvg_pkg::REG_NOISE_SEED: noise_seed_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[5:3])
         gvg_pkg::REG_MESH_MODE:  prdata = 64'(mesh_mode_ff);
         gvg_pkg::REG_GRID_LAST:  prdata = 64'(grid_last_ff);
         gvg_pkg::REG_ORIGIN_X:   prdata = 64'(origin_x_ff);
         gvg_pkg::REG_ORIGIN_Y:   prdata = 64'(origin_y_ff);
         gvg_pkg::REG_EXTENT_X:   prdata = 64'(extent_x_ff);
         gvg_pkg::REG_EXTENT_Y:   prdata = 64'(extent_y_ff);
         gvg_pkg::REG_JITTER:     prdata = 64'(jitter_ff);
         gvg_pkg::REG_NOISE_SEED: prdata = noise_seed_ff;
         default:                 prdata = '0;
      endcase
   end

   // Per-axis view of the configuration; axis 0 is x, axis 1 is y.
   logic [IB-1:0] last_w [2];
   logic [IB-1:0] raw_last [2];
   logic [30:0]   ext_w [2];
   logic [31:0]   org_w [2];
   logic [IB-1:0] idx_raw [2];
   logic [IB-1:0] idx_in [2];

   always_comb begin
      raw_last[0] = IB'(grid_last_ff[15:0]);
      raw_last[1] = IB'(grid_last_ff[31:16]);
      idx_raw[0]  = IB'(req_col_index);
      idx_raw[1]  = IB'(req_row_index);
      ext_w[0]    = extent_x_ff;
      ext_w[1]    = extent_y_ff;
      org_w[0]    = origin_x_ff;
      org_w[1]    = origin_y_ff;
      for (int a = 0; a < 2; a++) begin
         // A last index of zero counts as one; indices past the end are clamped.
         last_w[a] = (raw_last[a] == '0) ? IB'(1) : raw_last[a];
         idx_in[a] = (idx_raw[a] > last_w[a]) ? last_w[a] : idx_raw[a];
      end
   end

   // Input stage and the flag line that runs alongside the divider.
   gvg_pkg::side_type side_in;
   gvg_pkg::side_type side_ff [QW+1];
   logic [IB-1:0]     idx_ff [2];

   always_comb begin
      side_in.valid    = start;
      side_in.zero[0]  = (idx_in[0] == '0);
      side_in.zero[1]  = (idx_in[1] == '0);
      side_in.last[0]  = (idx_in[0] == last_w[0]);
      side_in.last[1]  = (idx_in[1] == last_w[1]);
      side_in.interior = !side_in.zero[0] && !side_in.last[0]
                         && !side_in.zero[1] && !side_in.last[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= QW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0] <= idx_in[0];
      idx_ff[1] <= idx_in[1];
   end

   // Dividers: offset q*extent/L, spacing extent/L and phase q*65536/L per axis.
   logic [NUM_W-1:0] num_uni [2];
   logic [NUM_W-1:0] num_spc [2];
   logic [NUM_W-1:0] num_phs [2];
   logic [QW-1:0]    quo_uni [2];
   logic [QW-1:0]    quo_spc [2];
   logic [QW-1:0]    quo_phs [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         num_uni[a] = NUM_W'(idx_ff[a]) * NUM_W'(ext_w[a]);
         num_spc[a] = NUM_W'(ext_w[a]);
         num_phs[a] = NUM_W'({idx_ff[a], 16'd0});
      end
   end

   for (genvar a = 0; a < 2; a++) begin : g_axis_div
      gvg_div #(.DEN_W(IB)) u_div_uni (
         .clock   (clock),
         .num_in  (num_uni[a]),
         .den_in  (last_w[a]),
         .quo_out (quo_uni[a])
      );
      gvg_div #(.DEN_W(IB)) u_div_spc (
         .clock   (clock),
         .num_in  (num_spc[a]),
         .den_in  (last_w[a]),
         .quo_out (quo_spc[a])
      );
      gvg_div #(.DEN_W(IB)) u_div_phs (
         .clock   (clock),
         .num_in  (num_phs[a]),
         .den_in  (last_w[a]),
         .quo_out (quo_phs[a])
      );
   end

   // Vertex key and the noise hashes; x hashes seed + 2*key, y the next value.
   logic [KEY_W-1:0]   key_ff;
   logic [63:0]        hash_in [2];
   gvg_pkg::noise_type hash_out [2];
   gvg_pkg::noise_type noise_dly_ff [2][NOISE_DLY];

   always_ff @(posedge clock) begin
      key_ff <= KEY_W'(idx_ff[1]) * KEY_W'({1'b0, last_w[0]} + 1'b1) + KEY_W'(idx_ff[0]);
   end

   always_comb begin
      hash_in[0] = noise_seed_ff + 64'({key_ff, 1'b0});
      hash_in[1] = noise_seed_ff + 64'({key_ff, 1'b1});
   end

   for (genvar a = 0; a < 2; a++) begin : g_axis_hash
      gvg_hash u_hash (
         .clock     (clock),
         .key_in    (hash_in[a]),
         .noise_out (hash_out[a])
      );
   end

   // Delay the noise so it meets the divider results.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         noise_dly_ff[a][0] <= hash_out[a];
         for (int j = 1; j < NOISE_DLY; j++) begin
            noise_dly_ff[a][j] <= noise_dly_ff[a][j-1];
         end
      end
   end

   // Post-division stages.
   gvg_pkg::side_type p1_side_ff, p2_side_ff, p3_side_ff, p4_side_ff;
   logic [30:0]        p1_uni_ff [2];
   logic [44:0]        p1_jh_ff [2];
   logic [KW-1:0]      p1_k_ff [2];
   logic [15:0]        p1_f_ff [2];
   gvg_pkg::noise_type p1_noise_ff [2];
   logic [30:0]        p2_uni_ff [2];
   logic [61:0]        p2_prod_ff [2];
   logic               p2_neg_ff [2];
   logic [16:0]        p2_a_ff [2];
   logic [16:0]        p2_d_ff [2];
   logic [15:0]        p2_f_ff [2];
   logic [30:0]        p3_uni_ff [2];
   logic signed [31:0] p3_disp_ff [2];
   logic [16:0]        p3_s_ff [2];
   logic [30:0]        p4_sine_ff [2];
   logic signed [33:0] p4_lin_ff [2];
   logic signed [31:0] coord_ff [2];
   logic               rsp_valid_ff;

   logic [KW+15:0]     phase_t [2];
   logic [16:0]        rom_a [2];
   logic [16:0]        rom_b [2];
   logic [16:0]        rom_d [2];
   logic [29:0]        disp_mag [2];
   logic signed [31:0] disp_in [2];
   logic signed [33:0] base_w [2];
   logic signed [31:0] coord_in [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         // Table position: k is the entry, the low 16 bits the fraction between entries.
         phase_t[a] = (KW+16)'(quo_phs[a][15:0]) * (KW+16)'(SINE_TABLE_DEPTH);

         // Table read and the rising step to the next entry.
         if (p1_k_ff[a] >= KW'(SINE_TABLE_DEPTH)) begin
            rom_a[a] = SINE_ROM[SINE_TABLE_DEPTH];
            rom_b[a] = SINE_ROM[SINE_TABLE_DEPTH];
         end else begin
            rom_a[a] = SINE_ROM[p1_k_ff[a]];
            rom_b[a] = SINE_ROM[KW'(p1_k_ff[a] + 1'b1)];
         end
         rom_d[a] = (rom_b[a] >= rom_a[a]) ? rom_b[a] - rom_a[a] : 17'd0;

         // Displacement, truncated toward zero, only for interior perturbed vertices.
         disp_mag[a] = p2_prod_ff[a][61:32];
         if (mesh_mode_ff == gvg_pkg::MODE_PERTURBED && p2_side_ff.interior) begin
            disp_in[a] = p2_neg_ff[a] ? -signed'({2'b00, disp_mag[a]})
                                      :  signed'({2'b00, disp_mag[a]});
         end else begin
            disp_in[a] = '0;
         end

         // Final selection: boundaries pin to the domain edges, else by mode.
         base_w[a] = 34'(signed'(org_w[a]));
         if (p4_side_ff.zero[a]) begin
            coord_in[a] = org_w[a];
         end else if (p4_side_ff.last[a]) begin
            coord_in[a] = gvg_pkg::sat32(base_w[a] + signed'(34'(ext_w[a])));
         end else if (mesh_mode_ff == gvg_pkg::MODE_SINE) begin
            coord_in[a] = gvg_pkg::sat32(base_w[a] + signed'(34'(p4_sine_ff[a])));
         end else begin
            coord_in[a] = gvg_pkg::sat32(base_w[a] + p4_lin_ff[a]);
         end
      end
   end

   // Flag stages after the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_side_ff   <= '0;
         p2_side_ff   <= '0;
         p3_side_ff   <= '0;
         p4_side_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_side_ff   <= side_ff[QW];
         p2_side_ff   <= p1_side_ff;
         p3_side_ff   <= p2_side_ff;
         p4_side_ff   <= p3_side_ff;
         rsp_valid_ff <= p4_side_ff.valid;
      end
   end

   // Data stages after the divider.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         p1_uni_ff[a]   <= quo_uni[a];
         p1_jh_ff[a]    <= 45'(jitter_ff) * 45'(quo_spc[a]);
         p1_k_ff[a]     <= phase_t[a][KW+15:16];
         p1_f_ff[a]     <= phase_t[a][15:0];
         p1_noise_ff[a] <= noise_dly_ff[a][NOISE_DLY-1];

         p2_uni_ff[a]   <= p1_uni_ff[a];
         p2_prod_ff[a]  <= 62'(p1_jh_ff[a]) * 62'(p1_noise_ff[a].mag);
         p2_neg_ff[a]   <= p1_noise_ff[a].neg;
         p2_a_ff[a]     <= rom_a[a];
         p2_d_ff[a]     <= rom_d[a];
         p2_f_ff[a]     <= p1_f_ff[a];

         p3_uni_ff[a]   <= p2_uni_ff[a];
         p3_disp_ff[a]  <= disp_in[a];
         p3_s_ff[a]     <= p2_a_ff[a] + 17'((33'(p2_d_ff[a]) * 33'(p2_f_ff[a])) >> 16);

         p4_sine_ff[a]  <= 31'((48'(ext_w[a]) * 48'(p3_s_ff[a])) >> 16);
         p4_lin_ff[a]   <= signed'(34'(p3_uni_ff[a])) + 34'(p3_disp_ff[a]);

         coord_ff[a]    <= coord_in[a];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_coord_x = coord_ff[0];
   assign rsp_coord_y = coord_ff[1];

endmodule

// ----- rtl/gvg_checker.sv -----
// Port-level assertions for the grid vertex generator, bound to its top level.
// Depends on gvg_pkg for the pipeline latency and register indexes.
module gvg_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [5:0]  paddr,
   input logic [63:0] pwdata,
   input logic [63:0] prdata
);

   localparam int LAT = gvg_pkg::LATENCY;

   // Every accepted transaction yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction accepted the latency earlier.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching accepted transaction");

   // A mode write is seen by a read in the next cycle.
   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[5:3] == gvg_pkg::REG_MESH_MODE)
      ##1 (psel && !pwrite && paddr[5:3] == gvg_pkg::REG_MESH_MODE)
      |-> prdata[1:0] == $past(pwdata[1:0]))
      else $error("mesh mode read-back differs from the written value");

endmodule

bind grid_vertex_generator gvg_checker u_gvg_checker (.*);
